/* rtl/sorted_priority_queue_defines.svh */
// Assertion macros for the sorted priority queue.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every edge once reset is released.
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check a property on every edge, reset included.
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define SPQ_ASSERT(lbl, prop, msg)
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* rtl/spq_pkg.sv */
// Shared types and constants of the sorted priority queue.
package spq_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned PRIO_W   = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  localparam logic ACT_INSERT  = 1'b0;
  localparam logic ACT_EXTRACT = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_EXTRACTED = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic signed [PRIO_W-1:0] prio;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic    load;
    logic    scan_init;
    logic    shift;
    logic    place;
    logic    head_read;
    logic    pop;
    logic    emit;
    status_e status;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic extract;
    logic full;
    logic empty;
    logic lt;
    logic last;
  } stat_t;

endpackage

/* rtl/spq_if.sv */
// Channel interfaces of the sorted priority queue: request words and result words.
interface spq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 action;
  logic signed [spq_pkg::DATA_W-1:0]    data_in;
  logic signed [spq_pkg::PRIO_W-1:0]    priority_in;

  modport source (output valid, action, data_in, priority_in, input ready);
  modport sink   (input valid, action, data_in, priority_in, output ready);
endinterface

interface spq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [spq_pkg::DATA_W-1:0]    data_out;
  logic        [spq_pkg::STATUS_W-1:0]  status;
  logic        [spq_pkg::COUNT_W-1:0]   entry_count;
  logic                                 empty_res;

  modport source (output valid, data_out, status, entry_count, empty_res, input ready);
  modport sink   (input valid, data_out, status, entry_count, empty_res, output ready);
endinterface

/* rtl/spq_ctrl.sv */
// Controller state machine of the sorted priority queue.
module spq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  input  spq_pkg::stat_t stat_i,
  output spq_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_PLACE,
    S_POP,
    S_EMIT
  } state_e;

  state_e            state_q, state_d;
  spq_pkg::status_e  res_q, res_d;
  logic              out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    cmd_o   = '0;
    cmd_o.status = res_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.extract) begin
          if (stat_i.empty) begin
            res_d   = spq_pkg::ST_EMPTY;
            state_d = S_EMIT;
          end else begin
            cmd_o.head_read = 1'b1;
            state_d         = S_POP;
          end
        end else if (stat_i.full) begin
          res_d   = spq_pkg::ST_FULL;
          state_d = S_EMIT;
        end else if (stat_i.empty) begin
          cmd_o.place = 1'b1;
          res_d       = spq_pkg::ST_INSERTED;
          state_d     = S_EMIT;
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d         = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.lt) begin
          // move the lower entry one slot toward the tail
          cmd_o.shift = 1'b1;
          if (stat_i.last) begin
            state_d = S_PLACE;
          end
        end else begin
          cmd_o.place = 1'b1;
          res_d       = spq_pkg::ST_INSERTED;
          state_d     = S_EMIT;
        end
      end
      S_PLACE: begin
        cmd_o.place = 1'b1;
        res_d       = spq_pkg::ST_INSERTED;
        state_d     = S_EMIT;
      end
      S_POP: begin
        cmd_o.pop = 1'b1;
        res_d     = spq_pkg::ST_EXTRACTED;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    out_valid_d = cmd_o.emit | (out_valid_q & ~out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_q       <= spq_pkg::ST_INSERTED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* rtl/spq_datapath.sv */
// Datapath of the sorted priority queue: circular entry store, pointers and result register.
module spq_datapath #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  spq_pkg::cmd_t                       cmd_i,
  output spq_pkg::stat_t                      stat_o,
  input  logic                                action_i,
  input  logic signed [spq_pkg::DATA_W-1:0]   data_in_i,
  input  logic signed [spq_pkg::PRIO_W-1:0]   priority_in_i,
  output logic signed [spq_pkg::DATA_W-1:0]   data_out_o,
  output logic        [spq_pkg::STATUS_W-1:0] status_o,
  output logic        [spq_pkg::COUNT_W-1:0]  entry_count_o,
  output logic                                empty_res_o
);

  localparam int unsigned PtrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned SumW = CntW + 1;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(CAPACITY - 1)) ? '0 : p + PtrW'(1);
  endfunction

  function automatic logic [PtrW-1:0] ptr_dec(input logic [PtrW-1:0] p);
    return (p == '0) ? PtrW'(CAPACITY - 1) : p - PtrW'(1);
  endfunction

  spq_pkg::entry_t mem [CAPACITY];

  logic                             act_q;
  spq_pkg::entry_t                  item_q;
  logic [PtrW-1:0]                  head_q, wr_q, rd_q;
  logic [CntW-1:0]                  cnt_q, remain_q;
  spq_pkg::entry_t                  rdata_q;
  logic signed [spq_pkg::DATA_W-1:0] popped_q;

  logic signed [spq_pkg::DATA_W-1:0] data_out_q;
  spq_pkg::status_e                  status_q;
  logic [spq_pkg::COUNT_W-1:0]       count_out_q;
  logic                              empty_out_q;

  logic [SumW-1:0]  tail_sum;
  logic [PtrW-1:0]  tail;
  logic             we;
  logic [PtrW-1:0]  waddr, raddr;
  spq_pkg::entry_t  wdata;

  // First free slot behind the last held entry
  assign tail_sum = SumW'(head_q) + SumW'(cnt_q);
  assign tail     = (tail_sum >= SumW'(CAPACITY)) ? PtrW'(tail_sum - SumW'(CAPACITY))
                                                  : PtrW'(tail_sum);

  always_comb begin
    we    = cmd_i.shift | cmd_i.place;
    waddr = wr_q;
    wdata = cmd_i.shift ? rdata_q : item_q;
    if (cmd_i.scan_init) begin
      raddr = ptr_dec(wr_q);
    end else if (cmd_i.shift) begin
      raddr = ptr_dec(rd_q);
    end else begin
      raddr = head_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q       <= action_i;
      item_q.data <= data_in_i;
      item_q.prio <= priority_in_i;
    end
    if (cmd_i.pop) begin
      popped_q <= rdata_q.data;
    end
    if (cmd_i.emit) begin
      data_out_q  <= (cmd_i.status == spq_pkg::ST_EXTRACTED) ? popped_q : '0;
      status_q    <= cmd_i.status;
      count_out_q <= spq_pkg::COUNT_W'(cnt_q);
      empty_out_q <= (cnt_q == '0);
    end
  end

  // Pointers and counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      cnt_q    <= '0;
      wr_q     <= '0;
      rd_q     <= '0;
      remain_q <= '0;
    end else begin
      if (cmd_i.load) begin
        wr_q <= tail;
      end
      if (cmd_i.scan_init) begin
        rd_q     <= ptr_dec(wr_q);
        remain_q <= cnt_q;
      end
      if (cmd_i.shift) begin
        wr_q     <= rd_q;
        rd_q     <= ptr_dec(rd_q);
        remain_q <= remain_q - CntW'(1);
      end
      if (cmd_i.place) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (cmd_i.pop) begin
        head_q <= ptr_inc(head_q);
        cnt_q  <= cnt_q - CntW'(1);
      end
    end
  end

  assign stat_o.extract = (act_q == spq_pkg::ACT_EXTRACT);
  assign stat_o.full    = (cnt_q == CntW'(CAPACITY));
  assign stat_o.empty   = (cnt_q == '0);
  assign stat_o.lt      = (rdata_q.prio < item_q.prio);
  assign stat_o.last    = (remain_q == CntW'(1));

  assign data_out_o    = data_out_q;
  assign status_o      = status_q;
  assign entry_count_o = count_out_q;
  assign empty_res_o   = empty_out_q;

endmodule

/* rtl/sorted_priority_queue.sv */
// Top level of the sorted priority queue: controller, datapath and channel ports.
//
// A bounded max-priority queue of CAPACITY entries, each a 32-bit data word with a
// signed 16-bit priority. Request words arrive on in_i: action 0 inserts data_in at
// priority_in behind every held entry of equal or higher priority; action 1 removes
// the head entry. Every request gives exactly one result word on out_o: data_out
// (the removed data, else zero), status, entry_count after the request, empty_res.
// Entries sit in a circular store with one write and one registered read port.
// An extract reads the head entry, then pops it; a rejected request or an insert into an
// empty queue goes straight to its result; any other insert scans from the tail, moving
// each held entry of lower priority one slot toward the tail per cycle, then places it.
// One request is in flight at a time: the next is taken the cycle after its result
// enters the output register. The output register lets a new request be accepted
// while the previous result waits; if the receiver stalls, the finished result waits
// inside until that register frees. Reset (rst_ni low, asynchronous) empties the
// queue and drops any pending word; the entry store itself is not cleared, since only
// held slots are ever read.
`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_in_if.sink    in_i,
  spq_out_if.source out_o
);

  spq_pkg::cmd_t  cmd;
  spq_pkg::stat_t stat;

  // Sequencing of each request word
  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Entry store, pointers and result payload
  spq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .action_i      (in_i.action),
    .data_in_i     (in_i.data_in),
    .priority_in_i (in_i.priority_in),
    .data_out_o    (out_o.data_out),
    .status_o      (out_o.status),
    .entry_count_o (out_o.entry_count),
    .empty_res_o   (out_o.empty_res)
  );

  // The store is never written while a new word can be taken
  `SPQ_ASSERT(a_no_write_when_ready, in_i.ready |-> !(cmd.shift || cmd.place), "store written while idle")
  // A dropped insert is reported only when the queue is really full
  `SPQ_ASSERT(a_full_report, (cmd.emit && cmd.status == spq_pkg::ST_FULL) |-> stat.full, "full status without full queue")
  // Pop only from a non-empty queue
  `SPQ_ASSERT(a_pop_nonempty, cmd.pop |-> !stat.empty, "pop from empty queue")
  // An entry is moved back only if it ranks below the new one
  `SPQ_ASSERT_ALWAYS(a_shift_lower, cmd.shift |-> stat.lt, "shift of an entry of equal or higher priority")

endmodule

/* tb/spq_order_checker.sv */
// Checker for the sorted priority queue: tracks held entries and compares result words.
module spq_order_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  spq_in_if           req_mon,
  spq_out_if          res_mon,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    status_e                  status;
    logic [COUNT_W-1:0]       count;
    logic                     empty;
  } result_t;

  entry_t  held_entries[$];   // head first, highest priority at index 0
  result_t expected_words[$];

  // Apply one request word to the held entries and return the result it gives.
  function automatic result_t apply_request(input logic act,
                                            input logic signed [DATA_W-1:0] data,
                                            input logic signed [PRIO_W-1:0] prio);
    result_t r;
    entry_t  e;
    int      pos;
    r = '0;
    if (act == ACT_INSERT) begin
      if (held_entries.size() >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        // Go behind every entry of equal or higher priority.
        while (pos < held_entries.size() && prio <= held_entries[pos].prio) pos++;
        e.data = data;
        e.prio = prio;
        held_entries.insert(pos, e);
        r.status = ST_INSERTED;
      end
    end else begin
      if (held_entries.size() == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.data = held_entries[0].data;
        void'(held_entries.pop_front());
        r.status = ST_EXTRACTED;
      end
    end
    r.count = COUNT_W'(held_entries.size());
    r.empty = (held_entries.size() == 0);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_w;
    if (!rst_ni) begin
      held_entries.delete();
      expected_words.delete();
      mismatch_cnt_o <= 0;
      pending_o      <= 0;
    end else begin
      if (req_mon.valid && req_mon.ready)
        expected_words.push_back(apply_request(req_mon.action, req_mon.data_in,
                                               req_mon.priority_in));
      if (res_mon.valid && res_mon.ready) begin
        if (expected_words.size() == 0) begin
          if (mismatch_cnt_o < 10)
            $display("%0t: result word with none expected: data %0d status %0d count %0d",
                     $realtime, res_mon.data_out, res_mon.status, res_mon.entry_count);
          mismatch_cnt_o <= mismatch_cnt_o + 1;
        end else begin
          exp_w = expected_words.pop_front();
          if (res_mon.data_out !== exp_w.data || res_mon.status !== exp_w.status ||
              res_mon.entry_count !== exp_w.count || res_mon.empty_res !== exp_w.empty) begin
            if (mismatch_cnt_o < 10)
              $display("%0t: mismatch: expected data %0d status %0d count %0d empty %0b,",
                       $realtime, exp_w.data, exp_w.status, exp_w.count, exp_w.empty,
                       " got data %0d status %0d count %0d empty %0b",
                       res_mon.data_out, res_mon.status, res_mon.entry_count,
                       res_mon.empty_res);
            mismatch_cnt_o <= mismatch_cnt_o + 1;
          end
        end
      end
      pending_o <= expected_words.size();
    end
  end

endmodule

/* tb/tb_sorted_priority_queue.sv */
// Testbench top of the sorted priority queue: stimulus, idling and verdict.
module tb_sorted_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned RANDOM_WORDS = 1825;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        idle_on = 1'b1;   // clear to run a stretch with no gaps or stalls
  int unsigned mismatch_cnt;
  int unsigned pending_cnt;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  sorted_priority_queue #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  spq_order_checker #(
    .CAPACITY(CAPACITY)
  ) order_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_mon       (in_ch),
    .res_mon       (out_ch),
    .mismatch_cnt_o(mismatch_cnt),
    .pending_o     (pending_cnt)
  );

  // 10 ns clock: high half, low half.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop: the slowest legal run (every insert shifting a full store,
  // every result held by receiver stalls) stays far below this.
  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  // Receiver side: hold ready low during reset, then stall in about 11 percent
  // of cycles while idling is on.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni)
        out_ch.ready <= 1'b0;
      else
        out_ch.ready <= !(idle_on && $urandom_range(99) < 11);
    end
  end

  // Offer one request word and hold it until the block takes it. Valid is left
  // high on return, so a back-to-back word never lowers and raises it in one step;
  // a gap lowers it only when one is drawn.
  task automatic send_word(input logic act, input logic signed [DATA_W-1:0] data,
                           input logic signed [PRIO_W-1:0] prio);
    while (idle_on && $urandom_range(99) < 11) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= act;
    in_ch.data_in     <= data;
    in_ch.priority_in <= prio;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // Draw a priority: half the time a narrow band so ties are common, some extremes,
  // the rest across the full range.
  function automatic logic signed [PRIO_W-1:0] draw_prio();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) return PRIO_W'($signed($urandom_range(8)) - 4);
    if (pick < 55) return {1'b0, {(PRIO_W-1){1'b1}}};
    if (pick < 60) return {1'b1, {(PRIO_W-1){1'b0}}};
    return PRIO_W'($urandom);
  endfunction

  initial begin
    int unsigned insert_pct;
    int unsigned mode_left;
    in_ch.valid       <= 1'b0;
    in_ch.action      <= ACT_INSERT;
    in_ch.data_in     <= '0;
    in_ch.priority_in <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Extract on an empty queue first.
    send_word(ACT_EXTRACT, 32'sd0, 16'sd0);
    // Fill the store with extreme data and priorities and several ties; ties
    // must leave in arrival order.
    send_word(ACT_INSERT, 32'sh7fffffff, 16'sd0);
    send_word(ACT_INSERT, 32'sh80000000, 16'sh7fff);
    send_word(ACT_INSERT, 32'sd0, 16'sh8000);
    send_word(ACT_INSERT, -32'sd1, 16'sd0);
    send_word(ACT_INSERT, 32'sd1, 16'sh7fff);
    send_word(ACT_INSERT, 32'sd2, 16'sh8000);
    send_word(ACT_INSERT, 32'sd3, 16'sd100);
    send_word(ACT_INSERT, 32'sd4, -16'sd100);
    send_word(ACT_INSERT, 32'sd5, 16'sd1);
    send_word(ACT_INSERT, 32'sd6, -16'sd1);
    send_word(ACT_INSERT, 32'sd7, 16'sd0);
    send_word(ACT_INSERT, 32'sd8, 16'sh7fff);
    send_word(ACT_INSERT, 32'sd9, 16'sh8000);
    send_word(ACT_INSERT, 32'sd10, 16'sd5);
    send_word(ACT_INSERT, 32'sd11, 16'sd5);
    send_word(ACT_INSERT, 32'sd12, 16'sd5);
    // Insert into a full queue: drop it.
    send_word(ACT_INSERT, 32'sd13, 16'sh7fff);
    // Drain part of it; the rest goes out in the random part.
    repeat (7) send_word(ACT_EXTRACT, 32'sh5a5a5a5a, 16'sh1234);

    // Random part: alternate fill, drain and balanced phases so the queue
    // swings between full and empty and hits both rejects often.
    insert_pct = 50;
    mode_left  = 0;
    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(80, 20);
        case ($urandom_range(2))
          0: insert_pct = 80;
          1: insert_pct = 20;
          default: insert_pct = 50;
        endcase
      end
      mode_left--;
      // Run a long stretch with no gaps and no stalls in the middle.
      idle_on <= !(n >= 700 && n < 1000);
      if ($urandom_range(99) < insert_pct)
        send_word(ACT_INSERT, DATA_W'($urandom), draw_prio());
      else
        send_word(ACT_EXTRACT, DATA_W'($urandom), PRIO_W'($urandom));
    end
    in_ch.valid <= 1'b0;
    // Let the checker count the last accepted word before reading its backlog.
    @(posedge clk_i);

    // Wait for the last result words, then give the block time to show
    // anything extra.
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatch_cnt == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
